// File: hw/rtl/v4sp_pkg.sv
// ----------------------------------------------------------------------------
// v4sp_pkg
// Shared types and constants for the version 4 signature packet parser.
// ----------------------------------------------------------------------------
package v4sp_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 184;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_PACKET = 2'd1;
    localparam logic [1:0] STATUS_BAD_FORMAT = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic        run_last;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [7:0]  signature_class;
        logic [7:0]  key_algorithm;
        logic [7:0]  digest_algorithm;
        logic [31:0] created_at;
        logic [63:0] issuer_id;
        logic [15:0] digest_prefix;
        logic [15:0] hashed_area_length;
        logic [15:0] payload_length;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// File: hw/rtl/v4sp_front.sv
// ----------------------------------------------------------------------------
// v4sp_front
// Byte parser: walks header, subpacket areas and prefix, emits result words.
// ----------------------------------------------------------------------------
module v4sp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_end,
    output v4sp_pkg::t_push o_push
);
    import v4sp_pkg::*;

    localparam logic [3:0] ST_VERSION  = 4'd0;
    localparam logic [3:0] ST_CLASS    = 4'd1;
    localparam logic [3:0] ST_KEYALG   = 4'd2;
    localparam logic [3:0] ST_HASHALG  = 4'd3;
    localparam logic [3:0] ST_HLEN_HI  = 4'd4;
    localparam logic [3:0] ST_HLEN_LO  = 4'd5;
    localparam logic [3:0] ST_SUB_LEN  = 4'd6;
    localparam logic [3:0] ST_SUB_LENX = 4'd7;
    localparam logic [3:0] ST_SUB_TYPE = 4'd8;
    localparam logic [3:0] ST_SUB_BODY = 4'd9;
    localparam logic [3:0] ST_ULEN_HI  = 4'd10;
    localparam logic [3:0] ST_ULEN_LO  = 4'd11;
    localparam logic [3:0] ST_PFX_HI   = 4'd12;
    localparam logic [3:0] ST_PFX_LO   = 4'd13;
    localparam logic [3:0] ST_PAYLOAD  = 4'd14;
    localparam logic [3:0] ST_ERROR    = 4'd15;

    localparam logic [7:0] SUB_CREATION = 8'd2;
    localparam logic [7:0] SUB_ISSUER   = 8'd16;
    localparam logic [7:0] VERSION_4    = 8'd4;
    localparam logic [7:0] LEN_TWO_BASE = 8'd192;
    localparam logic [7:0] LEN_FIVE     = 8'd255;
    localparam logic [2:0] MIN_BYTES    = 3'd7;

    logic [3:0]  r_stage,   n_stage;
    logic [2:0]  r_cnt,     n_cnt;
    logic [15:0] r_area,    n_area;
    logic [15:0] r_sub,     n_sub;
    logic [2:0]  r_seen,    n_seen;
    logic [7:0]  r_type,    n_type;
    logic [63:0] r_vs,      n_vs;
    logic [1:0]  r_err,     n_err;
    logic        r_unh,     n_unh;
    logic        r_in_area, n_in_area;
    logic [7:0]  r_class,   n_class;
    logic [7:0]  r_keyalg,  n_keyalg;
    logic [7:0]  r_digalg,  n_digalg;
    logic [31:0] r_created, n_created;
    logic [63:0] r_issuer,  n_issuer;
    logic [15:0] r_prefix,  n_prefix;
    logic [15:0] r_hlen,    n_hlen;
    logic [15:0] r_paylen,  n_paylen;

    always_comb begin
        logic [15:0] area_dec;
        logic [15:0] sub_dec;
        logic [15:0] open_len;
        logic [31:0] len;
        logic [1:0]  status;
        t_result     summ;
        t_result     pay;

        n_stage   = r_stage;
        n_cnt     = r_cnt;
        n_area    = r_area;
        n_sub     = r_sub;
        n_seen    = r_seen;
        n_type    = r_type;
        n_vs      = r_vs;
        n_err     = r_err;
        n_unh     = r_unh;
        n_in_area = r_in_area;
        n_class   = r_class;
        n_keyalg  = r_keyalg;
        n_digalg  = r_digalg;
        n_created = r_created;
        n_issuer  = r_issuer;
        n_prefix  = r_prefix;
        n_hlen    = r_hlen;
        n_paylen  = r_paylen;
        area_dec  = r_area - 16'd1;
        sub_dec   = r_sub - 16'd1;
        open_len  = {r_area[15:8], i_byte};
        len       = '0;
        status    = STATUS_OK;
        summ      = '0;
        pay       = '0;
        o_push    = '0;

        if (i_accept) begin
            if (r_cnt != MIN_BYTES) begin
                n_cnt = r_cnt + 3'd1;
            end
            if (r_stage == ST_PAYLOAD) begin
                pay.kind         = KIND_PAYLOAD;
                pay.payload_byte = i_byte;
                o_push.count     = 2'd1;
                o_push.first     = pay;
            end
            case (r_stage)
                ST_VERSION: begin
                    if (i_byte != VERSION_4) begin
                        n_err     = STATUS_BAD_FORMAT;
                        n_in_area = 1'b0;
                        n_stage   = ST_ERROR;
                    end else begin
                        n_stage = ST_CLASS;
                    end
                end
                ST_CLASS: begin
                    n_class = i_byte;
                    n_stage = ST_KEYALG;
                end
                ST_KEYALG: begin
                    n_keyalg = i_byte;
                    n_stage  = ST_HASHALG;
                end
                ST_HASHALG: begin
                    n_digalg = i_byte;
                    n_stage  = ST_HLEN_HI;
                end
                ST_HLEN_HI, ST_ULEN_HI: begin
                    n_area  = {i_byte, 8'h00};
                    n_stage = r_stage + 4'd1;
                end
                ST_HLEN_LO: begin
                    n_area  = open_len;
                    n_hlen  = open_len;
                    n_unh   = 1'b0;
                    n_stage = (open_len == 16'd0) ? ST_ULEN_HI : ST_SUB_LEN;
                end
                ST_ULEN_LO: begin
                    n_area  = open_len;
                    n_unh   = 1'b1;
                    n_stage = (open_len == 16'd0) ? ST_PFX_HI : ST_SUB_LEN;
                end
                ST_SUB_LEN: begin
                    n_area = area_dec;
                    if (i_byte < LEN_TWO_BASE) begin
                        len = {24'd0, i_byte};
                        if (len == 32'd0 || len > {16'd0, area_dec}) begin
                            n_err     = STATUS_BAD_PACKET;
                            n_in_area = 1'b0;
                            n_stage   = ST_ERROR;
                        end else begin
                            n_sub   = len[15:0];
                            n_stage = ST_SUB_TYPE;
                        end
                    end else begin
                        n_type = i_byte;
                        n_seen = (i_byte == LEN_FIVE) ? 3'd4 : 3'd1;
                        n_vs   = (i_byte == LEN_FIVE) ? 64'd0
                               : {48'd0, i_byte - LEN_TWO_BASE, 8'h00};
                        if (area_dec == 16'd0) begin
                            n_err     = STATUS_BAD_PACKET;
                            n_in_area = 1'b0;
                            n_stage   = ST_ERROR;
                        end else begin
                            n_stage = ST_SUB_LENX;
                        end
                    end
                end
                ST_SUB_LENX: begin
                    n_area = area_dec;
                    n_seen = r_seen - 3'd1;
                    if (r_type == LEN_FIVE) begin
                        n_vs = {32'd0, r_vs[23:0], i_byte};
                    end else begin
                        n_vs = r_vs + {56'd0, i_byte} + {56'd0, LEN_TWO_BASE};
                    end
                    len = n_vs[31:0];
                    if (n_seen == 3'd0) begin
                        if (len == 32'd0 || len > {16'd0, area_dec}) begin
                            n_err     = STATUS_BAD_PACKET;
                            n_in_area = 1'b0;
                            n_stage   = ST_ERROR;
                        end else begin
                            n_sub   = len[15:0];
                            n_stage = ST_SUB_TYPE;
                        end
                    end else if (area_dec == 16'd0) begin
                        n_err     = STATUS_BAD_PACKET;
                        n_in_area = 1'b0;
                        n_stage   = ST_ERROR;
                    end
                end
                ST_SUB_TYPE: begin
                    n_area = area_dec;
                    n_sub  = sub_dec;
                    n_type = i_byte;
                    n_vs   = '0;
                    if ((i_byte == SUB_CREATION && sub_dec != 16'd4) ||
                        (i_byte == SUB_ISSUER && sub_dec != 16'd8)) begin
                        n_err     = STATUS_BAD_FORMAT;
                        n_in_area = 1'b1;
                        n_stage   = ST_ERROR;
                    end else if (sub_dec != 16'd0) begin
                        n_stage = ST_SUB_BODY;
                    end else if (area_dec != 16'd0) begin
                        n_stage = ST_SUB_LEN;
                    end else begin
                        n_stage = r_unh ? ST_PFX_HI : ST_ULEN_HI;
                    end
                end
                ST_SUB_BODY: begin
                    n_area = area_dec;
                    n_sub  = sub_dec;
                    n_vs   = {r_vs[55:0], i_byte};
                    if (sub_dec == 16'd0) begin
                        if (r_type == SUB_CREATION) begin
                            n_created = n_vs[31:0];
                        end else if (r_type == SUB_ISSUER) begin
                            n_issuer = n_vs;
                        end
                        if (area_dec != 16'd0) begin
                            n_stage = ST_SUB_LEN;
                        end else begin
                            n_stage = r_unh ? ST_PFX_HI : ST_ULEN_HI;
                        end
                    end
                end
                ST_PFX_HI: begin
                    n_prefix = {i_byte, 8'h00};
                    n_stage  = ST_PFX_LO;
                end
                ST_PFX_LO: begin
                    n_prefix = {r_prefix[15:8], i_byte};
                    n_stage  = ST_PAYLOAD;
                end
                ST_PAYLOAD: begin
                    if (r_paylen != 16'hFFFF) begin
                        n_paylen = r_paylen + 16'd1;
                    end
                end
                default: begin
                    if (r_in_area && r_area != 16'd0) begin
                        n_area = area_dec;
                    end
                end
            endcase

            if (i_end) begin
                if (n_cnt != MIN_BYTES) begin
                    status = STATUS_BAD_PACKET;
                end else if (n_stage == ST_ERROR) begin
                    status = (n_err == STATUS_BAD_FORMAT && n_in_area && n_area != 16'd0)
                           ? STATUS_BAD_PACKET : n_err;
                end else if (n_stage != ST_PAYLOAD) begin
                    status = STATUS_BAD_PACKET;
                end else begin
                    status = STATUS_OK;
                end
                summ.kind     = KIND_SUMMARY;
                summ.run_last = 1'b1;
                summ.status   = status;
                if (status == STATUS_OK) begin
                    summ.signature_class    = n_class;
                    summ.key_algorithm      = n_keyalg;
                    summ.digest_algorithm   = n_digalg;
                    summ.created_at         = n_created;
                    summ.issuer_id          = n_issuer;
                    summ.digest_prefix      = n_prefix;
                    summ.hashed_area_length = n_hlen;
                    summ.payload_length     = n_paylen;
                end
                if (r_stage == ST_PAYLOAD) begin
                    o_push.count  = 2'd2;
                    o_push.second = summ;
                end else begin
                    o_push.count = 2'd1;
                    o_push.first = summ;
                end
                n_stage   = ST_VERSION;
                n_cnt     = '0;
                n_area    = '0;
                n_sub     = '0;
                n_seen    = '0;
                n_type    = '0;
                n_vs      = '0;
                n_err     = STATUS_OK;
                n_unh     = 1'b0;
                n_in_area = 1'b0;
                n_class   = '0;
                n_keyalg  = '0;
                n_digalg  = '0;
                n_created = '0;
                n_issuer  = '0;
                n_prefix  = '0;
                n_hlen    = '0;
                n_paylen  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage   <= ST_VERSION;
            r_cnt     <= '0;
            r_area    <= '0;
            r_sub     <= '0;
            r_seen    <= '0;
            r_type    <= '0;
            r_vs      <= '0;
            r_err     <= STATUS_OK;
            r_unh     <= 1'b0;
            r_in_area <= 1'b0;
            r_class   <= '0;
            r_keyalg  <= '0;
            r_digalg  <= '0;
            r_created <= '0;
            r_issuer  <= '0;
            r_prefix  <= '0;
            r_hlen    <= '0;
            r_paylen  <= '0;
        end else begin
            r_stage   <= n_stage;
            r_cnt     <= n_cnt;
            r_area    <= n_area;
            r_sub     <= n_sub;
            r_seen    <= n_seen;
            r_type    <= n_type;
            r_vs      <= n_vs;
            r_err     <= n_err;
            r_unh     <= n_unh;
            r_in_area <= n_in_area;
            r_class   <= n_class;
            r_keyalg  <= n_keyalg;
            r_digalg  <= n_digalg;
            r_created <= n_created;
            r_issuer  <= n_issuer;
            r_prefix  <= n_prefix;
            r_hlen    <= n_hlen;
            r_paylen  <= n_paylen;
        end
    end

endmodule

// File: hw/rtl/v4sp_queue.sv
// ----------------------------------------------------------------------------
// v4sp_queue
// Short result queue between parser and output stage, up to two writes per cycle.
// ----------------------------------------------------------------------------
module v4sp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  v4sp_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_valid,
    output v4sp_pkg::t_result o_head,
    output logic              o_room
);
    import v4sp_pkg::*;

    t_result           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, n_wr;
    logic [Q_AW-1:0]   r_rd, n_rd;
    logic [Q_CW-1:0]   r_cnt, n_cnt;
    logic [Q_AW-1:0]   wr_next;

    assign wr_next = r_wr + Q_AW'(1);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_room  = (r_cnt <= Q_CW'(Q_DEPTH - 2));

    always_comb begin
        n_wr  = r_wr + Q_AW'(i_push.count);
        n_rd  = i_pop ? r_rd + Q_AW'(1) : r_rd;
        n_cnt = r_cnt + Q_CW'(i_push.count) - Q_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: hw/rtl/v4sp_back.sv
// ----------------------------------------------------------------------------
// v4sp_back
// Output register stage: pops result words and holds them for the sink.
// ----------------------------------------------------------------------------
module v4sp_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  v4sp_pkg::t_result              i_q_head,
    output logic                           o_pop,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [v4sp_pkg::OUT_TDATA_W-1:0] o_tdata,
    output logic                           o_tlast,
    output logic                           o_tuser
);
    import v4sp_pkg::*;

    logic    r_valid, n_valid;
    t_result r_item;

    assign o_pop   = i_q_valid && (!r_valid || i_tready);
    assign n_valid = o_pop || (r_valid && !i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q_head;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tlast  = r_item.run_last;
    assign o_tuser  = r_item.kind;
    assign o_tdata  = {6'd0,
                       r_item.payload_length,
                       r_item.hashed_area_length,
                       r_item.digest_prefix,
                       r_item.issuer_id,
                       r_item.created_at,
                       r_item.digest_algorithm,
                       r_item.key_algorithm,
                       r_item.signature_class,
                       r_item.status,
                       r_item.payload_byte};

endmodule

// File: hw/rtl/v4_signature_packet_parser.sv
// ----------------------------------------------------------------------------
// v4_signature_packet_parser
// Version 4 signature packet body parser with payload pass-through and summary.
// ----------------------------------------------------------------------------
// Throughput: one body byte per cycle while the queue has room; the end byte
// may yield two words, which drain one per cycle through the four-entry queue
// while the sink is ready. A word is written into the queue when its byte is
// taken; with queue and output register empty it is registered out in the next cycle.
// Reset: synchronous, active low; clears parser state, queue and output stage.
module v4_signature_packet_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [v4sp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // data_byte
    input  logic                             i_s_axis_tlast,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // payload_byte, status, signature_class, key_algorithm, digest_algorithm,
    // created_at, issuer_id, digest_prefix, hashed_area_length, payload_length
    output logic [v4sp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                             o_m_axis_tlast,
    output logic                             o_m_axis_tuser   // kind
);
    import v4sp_pkg::*;

    t_push   push;
    t_result head;
    logic    q_valid;
    logic    q_room;
    logic    pop;

    assign o_s_axis_tready = q_room;

    v4sp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_s_axis_tvalid && q_room),
        .i_byte   (i_s_axis_tdata),
        .i_end    (i_s_axis_tlast),
        .o_push   (push)
    );

    v4sp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head),
        .o_room  (q_room)
    );

    v4sp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (head),
        .o_pop     (pop),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tlast   (o_m_axis_tlast),
        .o_tuser   (o_m_axis_tuser)
    );

endmodule

// File: hw/rtl/v4sp_checker.sv
// ----------------------------------------------------------------------------
// v4sp_checker
// Port-level checks on the parser's result stream.
// ----------------------------------------------------------------------------
module v4sp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [v4sp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                             o_m_axis_tlast,
    input logic                             o_m_axis_tuser
);
    import v4sp_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("Stalled output word changed.");

    a_last_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == o_m_axis_tuser))
        else $error("Run end and summary kind disagree.");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> (o_m_axis_tdata[OUT_TDATA_W-1:8] == '0))
        else $error("Payload word carries summary fields.");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser && (o_m_axis_tdata[9:8] != STATUS_OK) |->
            (o_m_axis_tdata[OUT_TDATA_W-1:10] == '0) && (o_m_axis_tdata[7:0] == '0))
        else $error("Error summary carries data fields.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Output valid right after reset.");

endmodule

bind v4_signature_packet_parser v4sp_checker u_v4sp_checker (.*);
